### src/nnu_pkg.sv
// Shared types and constants of the nearest-neighbor upscaler.
package nnu_pkg;

  localparam int unsigned PIX_W   = 24;
  localparam int unsigned SCALE_W = 6;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  localparam logic [IDX_W-1:0] CFG_SCALE  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

  // One source pixel together with how it is to be replicated.
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [SCALE_W-1:0] beats;
    logic               row_end;
    logic [1:0]         pad;
    logic               frame_end;
  } job_t;

endpackage

### src/nnu_front.sv
// Front end: accepts items, tracks the row and frame position, owns the line buffer.
module nnu_front #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_SCALE = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nnu_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_op_i,
  input  logic [nnu_pkg::PIX_W-1:0]       in_pixel_i,
  input  logic [nnu_pkg::QCNT_W-1:0]      q_level_i,
  output logic                            push_o,
  output nnu_pkg::job_t                   job_o
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_SCALE);
  localparam int unsigned DIM1  = nnu_pkg::DIM_W + 1;

  logic [nnu_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [nnu_pkg::PIX_W-1:0] rd_q;

  logic [nnu_pkg::DIM_W-1:0] column_q, column_d;
  logic [RW-1:0]             row_copy_q, row_copy_d;
  logic [nnu_pkg::DIM_W-1:0] source_row_q, source_row_d;
  logic                      phase_q, phase_d;

  logic                      stage_valid_q;
  logic                      tick_q;
  logic [nnu_pkg::PIX_W-1:0] pix_q;
  nnu_pkg::job_t             job_q, job_d;

  logic [nnu_pkg::SCALE_W-1:0] s_eff;
  logic [DIM1-1:0]             w_eff;
  logic [DIM1-1:0]             h_eff;
  logic [1:0]                  pad_mod;
  logic [1:0]                  pad;
  logic                        take;
  logic                        row_done, copies_done, frame_done;
  logic [AW-1:0]               addr;

  // Clamp the registers to the range the datapath supports.
  always_comb begin
    if (cfg_i.scale == '0) begin
      s_eff = nnu_pkg::SCALE_W'(1);
    end else if ((nnu_pkg::SCALE_W + 1)'(cfg_i.scale) > (nnu_pkg::SCALE_W + 1)'(MAX_SCALE)) begin
      s_eff = nnu_pkg::SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = cfg_i.scale;
    end
    if (cfg_i.width == '0) begin
      w_eff = DIM1'(1);
    end else if (DIM1'(cfg_i.width) > DIM1'(MAX_WIDTH)) begin
      w_eff = DIM1'(MAX_WIDTH);
    end else begin
      w_eff = DIM1'(cfg_i.width);
    end
    h_eff = (cfg_i.height == '0) ? DIM1'(1) : DIM1'(cfg_i.height);
  end

  // Only the low two bits of width and scale matter for the byte count mod 4.
  assign pad_mod = 2'(w_eff[1:0] * s_eff[1:0] * 2'd3);
  assign pad     = 2'd0 - pad_mod;

  // The stage register always drains into the queue, so room is reserved for it.
  assign in_ready_o = (nnu_pkg::QCNT_W'(q_level_i) + nnu_pkg::QCNT_W'(stage_valid_q))
                      < nnu_pkg::QCNT_W'(nnu_pkg::QDEPTH);
  assign take = in_valid_i && in_ready_o && (in_op_i == phase_q);
  assign addr = column_q[AW-1:0];

  assign row_done    = (DIM1'(column_q) + DIM1'(1)) >= w_eff;
  assign copies_done = (in_op_i == nnu_pkg::OP_PIXEL) ? (s_eff <= nnu_pkg::SCALE_W'(1))
                     : ((nnu_pkg::SCALE_W + 1)'(row_copy_q) + (nnu_pkg::SCALE_W + 1)'(1)
                        >= (nnu_pkg::SCALE_W + 1)'(s_eff));
  assign frame_done  = row_done && copies_done
                       && ((DIM1'(source_row_q) + DIM1'(1)) >= h_eff);

  always_comb begin
    column_d     = column_q;
    row_copy_d   = row_copy_q;
    source_row_d = source_row_q;
    phase_d      = phase_q;
    if (take) begin
      if (!row_done) begin
        column_d = column_q + nnu_pkg::DIM_W'(1);
      end else begin
        column_d = '0;
        if (!copies_done) begin
          row_copy_d = (in_op_i == nnu_pkg::OP_PIXEL) ? RW'(1) : row_copy_q + RW'(1);
          phase_d    = 1'b1;
        end else begin
          row_copy_d   = '0;
          phase_d      = 1'b0;
          source_row_d = frame_done ? '0 : source_row_q + nnu_pkg::DIM_W'(1);
        end
      end
    end
  end

  always_comb begin
    job_d           = '0;
    job_d.pixel     = in_pixel_i;
    job_d.beats     = s_eff;
    job_d.row_end   = row_done;
    job_d.pad       = row_done ? pad : 2'd0;
    job_d.frame_end = frame_done;
  end

  always_ff @(posedge clk_i) begin
    if (take && (in_op_i == nnu_pkg::OP_PIXEL)) begin
      line_mem[addr] <= in_pixel_i;
    end
    if (take && (in_op_i == nnu_pkg::OP_TICK)) begin
      rd_q <= line_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q      <= '0;
      row_copy_q    <= '0;
      source_row_q  <= '0;
      phase_q       <= 1'b0;
      stage_valid_q <= 1'b0;
    end else begin
      column_q      <= column_d;
      row_copy_q    <= row_copy_d;
      source_row_q  <= source_row_d;
      phase_q       <= phase_d;
      stage_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tick_q <= in_op_i;
      pix_q  <= in_pixel_i;
      job_q  <= job_d;
    end
  end

  always_comb begin
    job_o       = job_q;
    job_o.pixel = tick_q ? rd_q : pix_q;
  end
  assign push_o = stage_valid_q;

endmodule

### src/nnu_queue.sv
// Short job queue between the front end and the output sequencer.
module nnu_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  nnu_pkg::job_t              job_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output nnu_pkg::job_t              job_o,
  output logic [nnu_pkg::QCNT_W-1:0] level_o
);

  nnu_pkg::job_t               slots_q [nnu_pkg::QDEPTH];
  logic [nnu_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [nnu_pkg::QCNT_W-1:0]  count_q, count_d;

  always_comb begin
    count_d = count_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + nnu_pkg::QCNT_W'(1);
      2'b01:   count_d = count_q - nnu_pkg::QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + nnu_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + nnu_pkg::QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign job_o   = slots_q[rd_ptr_q];
  assign level_o = count_q;

endmodule

### src/nnu_back.sv
// Output sequencer: sends each queued pixel the requested number of beats.
module nnu_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  nnu_pkg::job_t             job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [nnu_pkg::PIX_W-1:0] out_pixel_o,
  output logic                      out_row_end_o,
  output logic [1:0]                out_pad_o,
  output logic                      out_frame_end_o,
  output logic                      out_last_o
);

  logic [nnu_pkg::SCALE_W-1:0] beat_q, beat_d;
  logic                        final_beat;
  logic                        fire;

  assign final_beat = (beat_q == (job_i.beats - nnu_pkg::SCALE_W'(1)));
  assign fire       = job_valid_i && out_ready_i;
  assign pop_o      = fire && final_beat;

  always_comb begin
    beat_d = beat_q;
    if (fire) begin
      beat_d = final_beat ? '0 : beat_q + nnu_pkg::SCALE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign out_valid_o     = job_valid_i;
  assign out_pixel_o     = job_i.pixel;
  assign out_row_end_o   = final_beat && job_i.row_end;
  assign out_pad_o       = final_beat ? job_i.pad : 2'd0;
  assign out_frame_end_o = final_beat && job_i.frame_end;
  assign out_last_o      = final_beat;

endmodule

### src/nearest_neighbor_upscaler.sv
// Top level of the nearest-neighbor integer image upscaler.
//
// Usage: program scale, src_width and src_height over the cfg channel while
// the block is idle (cfg_ready_o is always high; index 0 scale, 1 width,
// 2 height, other indexes are dropped). Source pixels then arrive on the
// slave stream with tuser = 0; after each complete source row the sender
// issues replay ticks (tuser = 1), one per pixel, for each extra copy of the
// row. An item of the kind not expected in the current phase is taken and
// dropped. Every other item yields scale beats on the master stream; tlast
// marks the final beat of an item, and that beat also carries the row-end
// flag, the pad byte count and the frame-end flag in tuser.
// An input beat passes one front-end stage, which also holds the line buffer
// read, and then the queue before the first beat of its item is valid. The
// output sequencer sends one output beat per cycle while the receiver is
// ready, scale beats per item. A four-entry queue parts the input from the
// output, so input beats keep flowing while the receiver stalls until the
// queue fills, and then tready drops. Reset empties the queue, returns to
// the filling phase at the first pixel of a frame and sets all registers to
// 1; the line buffer is not cleared.
module nearest_neighbor_upscaler #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_SCALE = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write channel.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [nnu_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [nnu_pkg::CFG_W-1:0]  cfg_data_i,
  // Input stream.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // [23:0] pixel
  input  logic [0:0]                 s_axis_tuser,  // [0] opcode
  // Output stream.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // [23:0] pixel_out
  output logic [3:0]                 m_axis_tuser,  // [0] row_end, [2:1] pad_bytes, [3] frame_end
  output logic                       m_axis_tlast
);

  nnu_pkg::cfg_t               cfg_q;
  logic                        push;
  nnu_pkg::job_t               push_job;
  logic                        head_valid;
  nnu_pkg::job_t               head_job;
  logic                        pop;
  logic [nnu_pkg::QCNT_W-1:0]  q_level;
  logic                        row_end;
  logic [1:0]                  pad;
  logic                        frame_end;

  // Register file; writes land directly. The user must keep the block idle meanwhile; the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale  <= nnu_pkg::SCALE_W'(1);
      cfg_q.width  <= nnu_pkg::DIM_W'(1);
      cfg_q.height <= nnu_pkg::DIM_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nnu_pkg::CFG_SCALE:  cfg_q.scale  <= cfg_data_i[nnu_pkg::SCALE_W-1:0];
        nnu_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data_i[nnu_pkg::DIM_W-1:0];
        nnu_pkg::CFG_HEIGHT: cfg_q.height <= cfg_data_i[nnu_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  nnu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser[0]),
    .in_pixel_i (s_axis_tdata),
    .q_level_i  (q_level),
    .push_o     (push),
    .job_o      (push_job)
  );

  nnu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job),
    .level_o (q_level)
  );

  nnu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (head_valid),
    .job_i           (head_job),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_pixel_o     (m_axis_tdata),
    .out_row_end_o   (row_end),
    .out_pad_o       (pad),
    .out_frame_end_o (frame_end),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tuser = {frame_end, pad, row_end};

endmodule

### test/tb_nearest_neighbor_upscaler.sv
// Self-checking testbench for the nearest-neighbor upscaler with its own pixel replication model.
`timescale 1ns / 100ps

module tb_nearest_neighbor_upscaler;

  localparam int unsigned MAX_WIDTH    = 4096;
  localparam int unsigned MAX_SCALE    = 32;
  localparam int unsigned LB_AW        = $clog2(MAX_WIDTH);
  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RST_CYCLES   = 6;
  // Hard ceiling on the whole run. The slowest correct run stays far below it.
  localparam int unsigned LIMIT        = 1_000_000;
  // Bound on one drain. Beats still missing after it are counted as lost.
  localparam int unsigned DRAIN_BOUND  = 100_000;
  // Covers the front-end stage plus the four-entry output queue, with some margin.
  localparam int unsigned DRAIN_PAUSE  = 8;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned NOISE_PCT    = 10;
  // Index with no register behind it. The block must drop writes to it.
  localparam logic [nnu_pkg::IDX_W-1:0] CFG_SPARE = 2'd3;

  // One input beat: the kind of item and its pixel.
  typedef struct packed {
    logic                      op;
    logic [nnu_pkg::PIX_W-1:0] pixel;
  } src_item_t;

  // One output beat, as the receiver expects it.
  typedef struct packed {
    logic [nnu_pkg::PIX_W-1:0] pixel;
    logic                      row_end;
    logic [1:0]                pad;
    logic                      frame_end;
    logic                      last;
  } out_beat_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [nnu_pkg::IDX_W-1:0]   cfg_index_i   = '0;
  logic [nnu_pkg::CFG_W-1:0]   cfg_data_i    = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [23:0]                 s_axis_tdata  = '0;  // [23:0] pixel
  logic [0:0]                  s_axis_tuser  = '0;  // [0] opcode
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [23:0]                 m_axis_tdata;        // [23:0] pixel_out
  logic [3:0]                  m_axis_tuser;  // [0] row_end, [2:1] pad_bytes, [3] frame_end
  logic                        m_axis_tlast;

  // Items still waiting for the driver, and output beats still owed by the block.
  src_item_t                   src_items_q[$];
  out_beat_t                   upscaled_q[$];

  // Shadow registers, written together with the block's registers.
  logic [nnu_pkg::SCALE_W-1:0] reg_scale  = nnu_pkg::SCALE_W'(1);
  logic [nnu_pkg::DIM_W-1:0]   reg_width  = nnu_pkg::DIM_W'(1);
  logic [nnu_pkg::DIM_W-1:0]   reg_height = nnu_pkg::DIM_W'(1);

  // Replication state of the model. The line buffer needs no reset, since the
  // stimulus never replays a column that was not filled first.
  logic [nnu_pkg::PIX_W-1:0]   line_buf [MAX_WIDTH];
  logic [nnu_pkg::DIM_W-1:0]   col      = '0;
  logic [4:0]                  copy_idx = '0;
  logic [nnu_pkg::DIM_W-1:0]   src_row  = '0;
  bit                          replaying = 1'b0;

  int unsigned        cycle_count    = 0;
  int unsigned        mismatch_count = 0;
  int unsigned        beats_in       = 0;
  int unsigned        beats_out      = 0;
  int unsigned        ignored_items  = 0;
  int unsigned        frames_done    = 0;
  int unsigned        cfg_writes     = 0;
  int unsigned        queued_items   = 0;

  // Sender burst and gap bookkeeping.
  int unsigned        burst_left = 0;
  int unsigned        gap_left   = 0;
  // Receiver stall pattern.
  int unsigned        rx_mode      = 0;
  int unsigned        rx_mode_left = 0;
  int unsigned        rx_phase     = 0;

  nearest_neighbor_upscaler #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SCALE(MAX_SCALE)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Register values outside the legal range act as the nearest legal value.
  function automatic int unsigned clamp_scale(input int unsigned raw);
    if (raw == 0) return 1;
    if (raw > MAX_SCALE) return MAX_SCALE;
    return raw;
  endfunction

  function automatic int unsigned clamp_width(input int unsigned raw);
    if (raw == 0) return 1;
    if (raw > MAX_WIDTH) return MAX_WIDTH;
    return raw;
  endfunction

  function automatic int unsigned clamp_height(input int unsigned raw);
    return (raw == 0) ? 1 : raw;
  endfunction

  function automatic logic [nnu_pkg::PIX_W-1:0] rand_pixel();
    return nnu_pkg::PIX_W'($urandom());
  endfunction

  // Works out the output beats of one accepted input beat and advances the
  // replication state. The register values in force at that moment apply, so a
  // row, its copies or the frame end as soon as a count reaches or passes
  // its limit.
  function automatic void replicate_pixel(input logic op,
                                          input logic [nnu_pkg::PIX_W-1:0] px_in);
    int unsigned               s, w, h, pad, k, c, ci, r;
    logic [nnu_pkg::PIX_W-1:0] px;
    bit                        row_done, copies_done, frame_done;
    out_beat_t                 b;
    s  = clamp_scale(32'(reg_scale));
    w  = clamp_width(32'(reg_width));
    h  = clamp_height(32'(reg_height));
    c  = 32'(col);
    ci = 32'(copy_idx);
    r  = 32'(src_row);
    // A tick while filling or a pixel while replaying is dropped without a trace.
    if (op != (replaying ? nnu_pkg::OP_TICK : nnu_pkg::OP_PIXEL)) begin
      ignored_items++;
      return;
    end
    if (op == nnu_pkg::OP_PIXEL) begin
      px = px_in;
      line_buf[LB_AW'(col)] = px;
    end else begin
      px = line_buf[LB_AW'(col)];
    end
    row_done    = (c + 1 >= w);
    copies_done = (op == nnu_pkg::OP_PIXEL) ? (s <= 1) : (ci + 1 >= s);
    frame_done  = row_done && copies_done && (r + 1 >= h);
    // Zero bytes that pad an output row of w*s three-byte pixels to a multiple of four.
    pad = (4 - (w * s * 3) % 4) % 4;
    for (k = 0; k < s; k++) begin
      b.pixel     = px;
      b.last      = (k + 1 == s);
      b.row_end   = b.last && row_done;
      b.pad       = b.row_end ? pad[1:0] : 2'd0;
      b.frame_end = b.last && frame_done;
      upscaled_q.push_back(b);
    end
    if (!row_done) begin
      col = col + nnu_pkg::DIM_W'(1);
    end else begin
      col = '0;
      if (!copies_done) begin
        copy_idx  = (op == nnu_pkg::OP_PIXEL) ? 5'd1 : copy_idx + 5'd1;
        replaying = 1'b1;
      end else begin
        copy_idx  = '0;
        replaying = 1'b0;
        if (frame_done) begin
          src_row = '0;
          frames_done++;
        end else begin
          src_row = src_row + nnu_pkg::DIM_W'(1);
        end
      end
    end
  endfunction

  function automatic void note_mismatch(input string what, input out_beat_t exp_beat,
                                        input out_beat_t got);
    string exp_s;
    string got_s;
    mismatch_count++;
    if (mismatch_count <= 10) begin
      exp_s = $sformatf("pixel %h row_end %b pad %0d frame_end %b last %b",
                        exp_beat.pixel, exp_beat.row_end, exp_beat.pad,
                        exp_beat.frame_end, exp_beat.last);
      got_s = $sformatf("pixel %h row_end %b pad %0d frame_end %b last %b",
                        got.pixel, got.row_end, got.pad, got.frame_end, got.last);
      $display("%s: expected %s, got %s", what, exp_s, got_s);
    end
  endfunction

  // Queues one item of the given kind. With a chance of noise_pct percent an
  // item of the wrong kind for the phase goes ahead of it; the block must drop it.
  function automatic void queue_item(input logic op, input logic [nnu_pkg::PIX_W-1:0] px,
                                     input int unsigned noise_pct);
    src_item_t it;
    if ($urandom_range(0, 99) < noise_pct) begin
      it.op    = ~op;
      it.pixel = rand_pixel();
      src_items_q.push_back(it);
    end
    it.op    = op;
    it.pixel = px;
    src_items_q.push_back(it);
    queued_items++;
  endfunction

  // Writes one register. Called only while the block is idle, from code that has just waited on the clock.
  task automatic write_reg(input logic [nnu_pkg::IDX_W-1:0] index, input int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= nnu_pkg::CFG_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (index)
      nnu_pkg::CFG_SCALE:  reg_scale  = nnu_pkg::SCALE_W'(value);
      nnu_pkg::CFG_WIDTH:  reg_width  = nnu_pkg::DIM_W'(value);
      nnu_pkg::CFG_HEIGHT: reg_height = nnu_pkg::DIM_W'(value);
      default: ;
    endcase
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds the stimulus back until every queued item has gone in and every owed beat
  // has come out or the drain bound runs out, counts missing beats as mismatches, then pauses.
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    while ((src_items_q.size() != 0 || s_axis_tvalid || upscaled_q.size() != 0)
           && waited < DRAIN_BOUND) begin
      @(posedge clk_i);
      waited++;
    end
    if (upscaled_q.size() != 0) begin
      $display("%0d expected output beats never arrived", upscaled_q.size());
      mismatch_count += upscaled_q.size();
      upscaled_q.delete();
    end
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  // Programs all three registers, then sends well-formed frames: each source
  // row as pixels followed by one tick per pixel for every extra copy of it,
  // with some out-of-phase noise mixed in.
  task automatic run_frames(input int unsigned raw_s, input int unsigned raw_w,
                            input int unsigned raw_h, input int unsigned n_frames);
    int unsigned s, w, h, f, r, c, k;
    write_reg(nnu_pkg::CFG_SCALE, raw_s);
    write_reg(nnu_pkg::CFG_WIDTH, raw_w);
    write_reg(nnu_pkg::CFG_HEIGHT, raw_h);
    s = clamp_scale(raw_s);
    w = clamp_width(raw_w);
    h = clamp_height(raw_h);
    for (f = 0; f < n_frames; f++) begin
      for (r = 0; r < h; r++) begin
        for (c = 0; c < w; c++) queue_item(nnu_pkg::OP_PIXEL, rand_pixel(), NOISE_PCT);
        for (k = 1; k < s; k++) begin
          for (c = 0; c < w; c++) queue_item(nnu_pkg::OP_TICK, rand_pixel(), NOISE_PCT);
        end
      end
    end
    wait_idle();
  endtask

  // Sender: takes items off the pending queue in bursts of random length with
  // random gaps in between, and now and then a long stretch without any gap.
  // Every beat accepted at an edge is handed to the model at that same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    src_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        replicate_pixel(s_axis_tuser[0], s_axis_tdata);
        beats_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || src_items_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = src_items_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.pixel;
          s_axis_tuser  <= nxt.op;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(32, 96);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(0, 11);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // Receiver: switches every so often between always ready, a coin toss,
  // mostly stalled and a fixed one-in-five stall.
  always @(posedge clk_i or negedge rst_ni) begin
    logic rdy_next;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      rx_phase = (rx_phase + 1) % 5;
      unique case (rx_mode)
        0:       rdy_next = 1'b1;
        1:       rdy_next = ($urandom_range(0, 1) == 1);
        2:       rdy_next = ($urandom_range(0, 3) == 0);
        default: rdy_next = (rx_phase != 0);
      endcase
      m_axis_tready <= rdy_next;
    end
  end

  // Monitor: every output beat is held against the oldest owed beat, field by field.
  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t exp_beat;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pixel     = m_axis_tdata;
      got.row_end   = m_axis_tuser[0];
      got.pad       = m_axis_tuser[2:1];
      got.frame_end = m_axis_tuser[3];
      got.last      = m_axis_tlast;
      beats_out++;
      if (upscaled_q.size() == 0) begin
        note_mismatch("Unexpected output beat", '0, got);
      end else begin
        exp_beat = upscaled_q.pop_front();
        if (got.pixel !== exp_beat.pixel || got.row_end !== exp_beat.row_end ||
            got.pad !== exp_beat.pad || got.frame_end !== exp_beat.frame_end ||
            got.last !== exp_beat.last)
          note_mismatch("Output beat mismatch", exp_beat, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles", LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned raw_s, raw_w, raw_h, pick, base_items;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: one pixel per frame, each sent once with row and frame end.
    // A tick while filling goes first and must be dropped; pixel extremes follow.
    queue_item(nnu_pkg::OP_PIXEL, 24'h000000, 100);
    queue_item(nnu_pkg::OP_PIXEL, 24'hFFFFFF, 0);
    wait_idle();

    // Zero in every register acts as one; the spare index must change nothing.
    write_reg(CFG_SPARE, $urandom());
    write_reg(nnu_pkg::CFG_SCALE, 0);
    write_reg(nnu_pkg::CFG_WIDTH, 0);
    write_reg(nnu_pkg::CFG_HEIGHT, 0);
    queue_item(nnu_pkg::OP_PIXEL, rand_pixel(), 0);
    queue_item(nnu_pkg::OP_PIXEL, rand_pixel(), 0);
    wait_idle();

    // A 2x2 block from a two-pixel row, with a wrong-kind item in each phase.
    write_reg(nnu_pkg::CFG_SCALE, 2);
    write_reg(nnu_pkg::CFG_WIDTH, 2);
    write_reg(nnu_pkg::CFG_HEIGHT, 1);
    queue_item(nnu_pkg::OP_PIXEL, rand_pixel(), 100);
    queue_item(nnu_pkg::OP_PIXEL, rand_pixel(), 0);
    queue_item(nnu_pkg::OP_TICK, rand_pixel(), 100);
    queue_item(nnu_pkg::OP_TICK, rand_pixel(), 0);
    wait_idle();

    // Width above the maximum, then narrowed in the middle of the row: the
    // next pixel closes the row, and two replayed copies of three pixels follow.
    write_reg(nnu_pkg::CFG_SCALE, 3);
    write_reg(nnu_pkg::CFG_WIDTH, 8191);
    write_reg(nnu_pkg::CFG_HEIGHT, 1);
    repeat (5) queue_item(nnu_pkg::OP_PIXEL, rand_pixel(), 0);
    wait_idle();
    write_reg(nnu_pkg::CFG_WIDTH, 3);
    queue_item(nnu_pkg::OP_PIXEL, rand_pixel(), 0);
    repeat (6) queue_item(nnu_pkg::OP_TICK, rand_pixel(), 0);
    wait_idle();

    // Scale lowered while replaying: the copy count has already passed the new
    // limit, so the row in progress is the last copy.
    write_reg(nnu_pkg::CFG_SCALE, 4);
    write_reg(nnu_pkg::CFG_WIDTH, 2);
    write_reg(nnu_pkg::CFG_HEIGHT, 1);
    repeat (2) queue_item(nnu_pkg::OP_PIXEL, rand_pixel(), 0);
    repeat (2) queue_item(nnu_pkg::OP_TICK, rand_pixel(), 0);
    wait_idle();
    write_reg(nnu_pkg::CFG_SCALE, 2);
    repeat (2) queue_item(nnu_pkg::OP_TICK, rand_pixel(), 0);
    wait_idle();

    // Largest height, cut down after two rows: the third row ends the frame.
    write_reg(nnu_pkg::CFG_SCALE, 1);
    write_reg(nnu_pkg::CFG_WIDTH, 3);
    write_reg(nnu_pkg::CFG_HEIGHT, 8191);
    repeat (6) queue_item(nnu_pkg::OP_PIXEL, rand_pixel(), 0);
    wait_idle();
    write_reg(nnu_pkg::CFG_HEIGHT, 1);
    repeat (3) queue_item(nnu_pkg::OP_PIXEL, rand_pixel(), 0);
    wait_idle();

    // A small frame at the largest scale, and a scale above the maximum that
    // must act as the maximum.
    run_frames(32, 2, 2, 1);
    run_frames(63, 1, 0, 1);

    // Random frames. Small scales dominate; large scales get tiny frames so
    // that no single frame runs long.
    base_items = queued_items;
    while (queued_items - base_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       raw_s = 0;
      else if (pick < 75) raw_s = $urandom_range(1, 4);
      else if (pick < 90) raw_s = $urandom_range(5, 32);
      else                raw_s = $urandom_range(33, 63);
      if (clamp_scale(raw_s) > 8) begin
        raw_w = $urandom_range(1, 2);
        raw_h = $urandom_range(0, 2);
      end else begin
        raw_w = $urandom_range(0, 6);
        raw_h = $urandom_range(0, 3);
      end
      run_frames(raw_s, raw_w, raw_h, $urandom_range(1, 2));
    end

    wait_idle();
    $display("Run covered %0d input beats (%0d dropped as out of phase), %0d output beats,",
             beats_in, ignored_items, beats_out);
    $display("%0d complete frames and %0d register writes.", frames_done, cfg_writes);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
